// ===== hw/rtl/ssbp_pkg.sv =====
`default_nettype none
package ssbp_pkg;

	// Queue entry passed from the front end to the frame builder
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       first;
	} ssbp_entry_t;

	typedef enum logic [1:0] {
		ST_TAKE,
		ST_HDR,
		ST_GRP,
		ST_END
	} ssbp_state_t;

	localparam int unsigned HdrLen   = 5;
	localparam int unsigned GrpLen   = 7;
	localparam logic [7:0]  EoxByte  = 8'hF7;
	localparam logic [7:0]  TempoMin = 8'd40;
	localparam logic [7:0]  TempoMax = 8'd240;
	localparam int unsigned TempoLoPos = 109;
	localparam int unsigned TempoHiPos = 110;

	function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'hF0;
			3'd1: b = 8'h52;
			3'd2: b = 8'h00;
			3'd3: b = 8'h61;
			3'd4: b = 8'h28;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ssbp_if.sv =====
`default_nettype none
interface ssbp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ssbp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sysex_seven_bit_packer_core.sv =====
`default_nettype none
// Streams patch bytes into a sysex frame: header F0 52 00 61 28 before the first
// byte, then 8-to-7 packed groups (top-bit byte plus seven low parts), then a final
// partial group and F7 on the byte marked last. The front end applies the tempo
// patch at positions 109 and 110 and feeds a four-entry queue; the frame builder
// behind it emits one byte per cycle into an output register while the output is not
// stalled. An item that does not complete a group is taken from the queue without output;
// one that completes a group holds the builder while its top-bit byte and seven low parts
// are sent. The header adds five bytes per frame. The output byte rate of the builder is
// the limit; the queue lets input be taken while a group is being sent.
module sysex_seven_bit_packer_core #(
	parameter int unsigned MAX_BYTES = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	ssbp_in_if.sink         in_ch,
	ssbp_out_if.source      out_ch
);

	logic                  q_full;
	logic                  push;
	logic                  pop;
	logic                  head_valid;
	ssbp_pkg::ssbp_entry_t push_entry;
	ssbp_pkg::ssbp_entry_t head_entry;

	ssbp_front #(
		.MAX_BYTES(MAX_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push      (push),
		.push_entry(push_entry)
	);

	ssbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_entry(head_entry)
	);

	ssbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_entry(head_entry),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/ssbp_front.sv =====
`default_nettype none
module ssbp_front #(
	parameter int unsigned MAX_BYTES = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [7:0]     cfg_data,
	ssbp_in_if.sink             in_ch,
	input  wire logic           q_full,
	output logic                push,
	output ssbp_pkg::ssbp_entry_t push_entry
);

	localparam int unsigned PosW = $clog2(MAX_BYTES);

	logic [7:0]      tempo_q;
	logic [PosW-1:0] pos_q;
	logic            hdr_sent_q;
	logic            tempo_ok;
	logic [7:0]      b;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	assign tempo_ok = (tempo_q >= ssbp_pkg::TempoMin) && (tempo_q <= ssbp_pkg::TempoMax);

	always_comb begin
		b = in_ch.data_byte;
		if (tempo_ok && pos_q == PosW'(ssbp_pkg::TempoLoPos)) begin
			// tempo bit 2 lands on the top bit, bit 4 is cleared
			b = {in_ch.data_byte[7] | tempo_q[2], tempo_q[1:0], 1'b0, in_ch.data_byte[3:0]};
		end else if (tempo_ok && pos_q == PosW'(ssbp_pkg::TempoHiPos)) begin
			b = {in_ch.data_byte[7:5], tempo_q[7:3]};
		end
	end

	assign push_entry.data  = b;
	assign push_entry.last  = in_ch.last_byte;
	assign push_entry.first = !hdr_sent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q    <= '0;
			pos_q      <= '0;
			hdr_sent_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tempo_q <= cfg_data;
			end
			if (push) begin
				if (in_ch.last_byte) begin
					// frame closes: next item opens a new one
					pos_q      <= '0;
					hdr_sent_q <= 1'b0;
				end else begin
					hdr_sent_q <= 1'b1;
					if (pos_q != PosW'(MAX_BYTES - 1)) begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ssbp_queue.sv =====
`default_nettype none
module ssbp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  ssbp_pkg::ssbp_entry_t push_entry,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output ssbp_pkg::ssbp_entry_t head_entry
);

	localparam int unsigned Depth = 4;
	localparam int unsigned PtrW  = $clog2(Depth);

	ssbp_pkg::ssbp_entry_t mem_q [Depth];
	logic [PtrW-1:0]       wr_ptr_q;
	logic [PtrW-1:0]       rd_ptr_q;
	logic [PtrW:0]         count_q;

	assign full       = count_q == (PtrW + 1)'(Depth);
	assign head_valid = count_q != '0;
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ssbp_back.sv =====
`default_nettype none
module ssbp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  ssbp_pkg::ssbp_entry_t head_entry,
	output logic                  pop,
	ssbp_out_if.source            out_ch
);

	ssbp_pkg::ssbp_state_t state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic       last_q;
	logic [6:0] grp_low_q [ssbp_pkg::GrpLen];
	logic [6:0] grp_top_q;
	logic [2:0] grp_fill_q;
	logic       grp_clr;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_end_q;

	logic       emit_ok;
	logic       emit;
	logic [7:0] emit_byte;
	logic       emit_end;
	logic [2:0] low_idx;

	assign emit_ok = !out_valid_q || out_ch.ready;
	assign low_idx = cnt_q - 3'd1;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_byte = '0;
		emit_end  = 1'b0;
		grp_clr   = 1'b0;
		unique case (state_q)
			ssbp_pkg::ST_TAKE: begin
				if (head_valid) begin
					pop   = 1'b1;
					cnt_d = '0;
					if (head_entry.first) begin
						state_d = ssbp_pkg::ST_HDR;
					end else if (grp_fill_q == 3'(ssbp_pkg::GrpLen - 1)
							|| head_entry.last) begin
						state_d = ssbp_pkg::ST_GRP;
					end
				end
			end
			ssbp_pkg::ST_HDR: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_byte = ssbp_pkg::hdr_byte(cnt_q);
					if (cnt_q == 3'(ssbp_pkg::HdrLen - 1)) begin
						cnt_d = '0;
						if (grp_fill_q == 3'(ssbp_pkg::GrpLen) || last_q) begin
							state_d = ssbp_pkg::ST_GRP;
						end else begin
							state_d = ssbp_pkg::ST_TAKE;
						end
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
			end
			ssbp_pkg::ST_GRP: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_byte = (cnt_q == '0) ? {1'b0, grp_top_q} : {1'b0, grp_low_q[low_idx]};
					if (cnt_q == grp_fill_q) begin
						grp_clr = 1'b1;
						cnt_d   = '0;
						// a full group on the last item is followed by an empty one
						if (!last_q) begin
							state_d = ssbp_pkg::ST_TAKE;
						end else if (grp_fill_q == 3'(ssbp_pkg::GrpLen)) begin
							state_d = ssbp_pkg::ST_GRP;
						end else begin
							state_d = ssbp_pkg::ST_END;
						end
					end else begin
						cnt_d = cnt_q + 3'd1;
					end
				end
			end
			ssbp_pkg::ST_END: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_byte = ssbp_pkg::EoxByte;
					emit_end  = 1'b1;
					state_d   = ssbp_pkg::ST_TAKE;
				end
			end
			default: begin
				state_d = ssbp_pkg::ST_TAKE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_low_q[grp_fill_q] <= head_entry.data[6:0];
		end
		if (emit) begin
			out_byte_q <= emit_byte;
			out_end_q  <= emit_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssbp_pkg::ST_TAKE;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			grp_top_q   <= '0;
			grp_fill_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (pop) begin
				last_q     <= head_entry.last;
				grp_top_q  <= grp_top_q | (7'(head_entry.data[7]) << (3'd6 - grp_fill_q));
				grp_fill_q <= grp_fill_q + 3'd1;
			end else if (grp_clr) begin
				grp_top_q  <= '0;
				grp_fill_q <= '0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.frame_byte = out_byte_q;
	assign out_ch.frame_end  = out_end_q;

endmodule
`default_nettype wire

// ===== verif/sysex_seven_bit_packer_core_test.sv =====
`timescale 1ns / 1ps
module sysex_seven_bit_packer_core_test;

	// A small patch limit lets a single frame run past the saturation point
	localparam int unsigned PatchMax     = 128;
	localparam int unsigned CycleLimit   = 400000;
	localparam int unsigned SettleCycles = 24;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_out_t;

	class frame_tracker;
		logic [7:0]  tempo;
		logic [6:0]  low_parts [ssbp_pkg::GrpLen];
		logic [6:0]  top_bits;
		int unsigned fill;
		int unsigned position;
		bit          header_out;
		frame_out_t  expected_frame [$];
		int unsigned errors;
		int unsigned items_taken;
		int unsigned bytes_checked;
		int unsigned frames_closed;

		function new();
			tempo = 8'd0;
			errors = 0;
			items_taken = 0;
			bytes_checked = 0;
			frames_closed = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			for (int i = 0; i < ssbp_pkg::GrpLen; i++) begin
				low_parts[i] = 7'd0;
			end
			top_bits = 7'd0;
			fill = 0;
			position = 0;
			header_out = 1'b0;
		endfunction

		function void push_out(logic [7:0] b, logic e);
			frame_out_t r;
			r.frame_byte = b;
			r.frame_end = e;
			expected_frame = {expected_frame, r};
		endfunction

		function void emit_group();
			push_out({1'b0, top_bits}, 1'b0);
			for (int unsigned i = 0; i < fill; i++) begin
				push_out({1'b0, low_parts[i]}, 1'b0);
			end
			top_bits = 7'd0;
			fill = 0;
		endfunction

		function void note_patch_byte(logic [7:0] raw, logic last);
			logic [7:0] b;
			b = raw;
			items_taken++;
			if (!header_out) begin
				push_out(8'hF0, 1'b0);
				push_out(8'h52, 1'b0);
				push_out(8'h00, 1'b0);
				push_out(8'h61, 1'b0);
				push_out(8'h28, 1'b0);
				header_out = 1'b1;
			end
			// Patch tempo fields into the two fixed positions
			if (tempo >= ssbp_pkg::TempoMin && tempo <= ssbp_pkg::TempoMax) begin
				if (position == ssbp_pkg::TempoLoPos) begin
					b = (b & 8'h80) | ({5'd0, tempo[2:0]} << 5) | (b & 8'h0F);
				end else if (position == ssbp_pkg::TempoHiPos) begin
					b = (b & 8'hE0) | (tempo >> 3);
				end
			end
			if (position < PatchMax - 1) position++;
			if (fill > 6) fill = 6;
			if (b[7]) top_bits = top_bits | (7'd1 << (6 - fill));
			low_parts[fill] = b[6:0];
			fill++;
			if (fill == ssbp_pkg::GrpLen) emit_group();
			if (last) begin
				emit_group();
				push_out(ssbp_pkg::EoxByte, 1'b1);
				frames_closed++;
				clear_frame();
			end
		endfunction

		function void check_frame_byte(logic [7:0] fb, logic fe);
			frame_out_t want;
			if (expected_frame.size() == 0) begin
				$error("unexpected frame byte %02h (frame_end %0b)", fb, fe);
				errors++;
				return;
			end
			want = expected_frame.pop_front();
			bytes_checked++;
			if (fb !== want.frame_byte) begin
				$error("frame_byte: expected %02h, got %02h", want.frame_byte, fb);
				errors++;
			end
			if (fe !== want.frame_end) begin
				$error("frame_end: expected %0b, got %0b", want.frame_end, fe);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_data;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycle_count = 0;
	frame_tracker tracker;

	ssbp_in_if  in_ch ();
	ssbp_out_if out_ch ();

	sysex_seven_bit_packer_core #(
		.MAX_BYTES(PatchMax)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			tracker.check_frame_byte(out_ch.frame_byte, out_ch.frame_end);
		end
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_patch_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
		tracker.note_patch_byte(b, last);
	endtask

	// Hold the input low until every expected frame byte is out
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (tracker.expected_frame.size() != 0);
	endtask

	task automatic send_patch(input logic [7:0] body [$], input int pause_at);
		for (int i = 0; i < body.size(); i++) begin
			if (i == pause_at) drain_results();
			send_patch_byte(body[i], i == body.size() - 1);
		end
	endtask

	task automatic send_random_patch(input int len, input int pause_at);
		logic [7:0] body [$];
		for (int i = 0; i < len; i++) begin
			body = {body, 8'($urandom)};
		end
		send_patch(body, pause_at);
	endtask

	task automatic write_tempo(input logic [7:0] value);
		drain_results();
		repeat (SettleCycles) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.tempo = value;
	endtask

	initial begin
		logic [7:0]  tempo_plan [8];
		int          long_len [8];
		int unsigned phase_start;
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 8'd0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'd0;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One-byte frames at both extremes, a group that fills on the last byte,
		// and partial groups of one and six
		send_patch({8'h00}, -1);
		send_patch({8'hFF}, -1);
		send_patch({8'h80, 8'h7F, 8'hFF, 8'h00, 8'h01, 8'hFE, 8'h80}, -1);
		send_patch({8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h7F, 8'h01, 8'hFE}, -1);
		send_patch({8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'hA0}, -1);

		tempo_plan = '{8'd40, 8'd240, 8'd39, 8'd241, 8'd255,
			8'($urandom_range(239, 41)), 8'd0, 8'($urandom_range(255))};
		// The first long frame runs past the saturation point of the position
		long_len = '{131, 111, 0, 0, 0, 0, 0, 0};
		for (int p = 0; p < 8; p++) begin
			write_tempo(tempo_plan[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			phase_start = tracker.items_taken;
			if (long_len[p] > 0) send_random_patch(long_len[p], -1);
			if (p == 4) send_random_patch(12, 9);
			while (tracker.items_taken - phase_start < 8) begin
				send_random_patch($urandom_range(12, 1), -1);
			end
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain_results();
		repeat (SettleCycles) @(posedge clk);
		$display("Accepted %0d patch bytes in %0d frames, checked %0d frame bytes",
			tracker.items_taken, tracker.frames_closed, tracker.bytes_checked);
		$display("Tempo 0, 39, 40, 240, 241, 255 and random; tempo patch hit at 40 and 240, %0s%0d",
			"one frame past position ", PatchMax - 1);
		if (tracker.errors == 0 && tracker.expected_frame.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/ssbp_pkg.sv
hw/rtl/ssbp_if.sv
hw/rtl/ssbp_front.sv
hw/rtl/ssbp_queue.sv
hw/rtl/ssbp_back.sv
hw/rtl/sysex_seven_bit_packer_core.sv
verif/sysex_seven_bit_packer_core_test.sv
